// ===== rtl/stl_pkg.sv =====
// Shared types and constants for the serialized trie lookup block.
package stl_pkg;

   localparam int unsigned MEM_BYTES_DEFAULT = 4096;
   localparam int unsigned ROOT_W = 12;
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_KEY = 1'b1;

   localparam logic [7:0] KEY_END = 8'h00;

   localparam logic REG_ROOT_OFFSET = 1'b0;

   localparam logic [2:0] OFF_LAST = 3'd3;
   localparam logic [2:0] VAL_LAST = 3'd7;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_COUNT,
      ST_HASVAL,
      ST_SCAN,
      ST_OFFSET,
      ST_VALUE
   } state_type;

endpackage

// ===== rtl/serialized_trie_lookup.sv =====
// Top level of the serialized trie lookup: trie memory, walk sequencer and register port.
// A memory write, and any key byte after a miss, is taken in the idle state. Otherwise a key byte reads
// the child count and value flag of the node header, then scans child key bytes one per cycle: a match
// reads the 4-byte child offset, a miss ends the scan, and an end of key reads the 8-byte value if flagged.
// The result strobe comes in the cycle after the last step, with busy low again, and is never held.
// Synchronous reset clears the walk to root offset 0; the trie memory is not cleared.
module serialized_trie_lookup #(
   parameter int unsigned MEM_BYTES = stl_pkg::MEM_BYTES_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_cmd,
   input  logic [11:0]                    req_addr,
   input  logic [7:0]                     req_data_byte,
   output logic                           rsp_strobe,
   output logic                           rsp_found,
   output logic [63:0]                    rsp_value,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [stl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [stl_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [stl_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   localparam int unsigned AW = $clog2(MEM_BYTES);

   logic [7:0] mem [MEM_BYTES];
   logic [7:0] mem_q_ff;
   logic       mem_we;
   logic [AW-1:0] wr_addr;

   stl_pkg::state_type state_ff, state_in;
   logic [AW-1:0] ptr_ff, ptr_in;
   logic [AW-1:0] node_ff, node_in;
   logic          missed_ff, missed_in;
   logic [stl_pkg::ROOT_W-1:0] root_ff, root_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    idx_ff, idx_in;
   logic [2:0]    bcnt_ff, bcnt_in;
   logic [7:0]    key_ff, key_in;
   logic [63:0]   shift_ff, shift_in;
   logic [63:0]   shift_next;
   logic          rsp_strobe_ff, rsp_strobe_in;
   logic          rsp_found_ff, rsp_found_in;
   logic [63:0]   rsp_value_ff, rsp_value_in;
   logic          cfg_we;
   logic [10:0]   val_pos;
   logic [10:0]   off_pos;

   assign pready = 1'b1;
   assign cfg_we = psel && penable && pwrite && pready && (paddr[2] == stl_pkg::REG_ROOT_OFFSET);
   assign prdata = (paddr[2] == stl_pkg::REG_ROOT_OFFSET) ?
                   {{(stl_pkg::CSR_DATA_W - stl_pkg::ROOT_W){1'b0}}, root_ff} : '0;

   assign busy       = (state_ff != stl_pkg::ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_value  = rsp_value_ff;

   assign wr_addr    = AW'(req_addr);
   assign shift_next = {mem_q_ff, shift_ff[63:8]};
   assign val_pos    = 11'd2 + {1'b0, count_ff, 2'b00} + {3'b000, count_ff};
   assign off_pos    = 11'd2 + {3'b000, count_ff} + {1'b0, idx_ff, 2'b00};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= req_data_byte;
      end
      mem_q_ff <= mem[ptr_in];
   end

   always_comb begin
      state_in      = state_ff;
      ptr_in        = ptr_ff;
      node_in       = node_ff;
      missed_in     = missed_ff;
      root_in       = root_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      bcnt_in       = bcnt_ff;
      key_in        = key_ff;
      shift_in      = shift_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_value_in  = rsp_value_ff;
      mem_we        = 1'b0;

      case (state_ff)
         stl_pkg::ST_IDLE: begin
            if (start) begin
               if (req_cmd == stl_pkg::CMD_WRITE) begin
                  mem_we = 1'b1;
               end else if (missed_ff) begin
                  if (req_data_byte == stl_pkg::KEY_END) begin
                     rsp_strobe_in = 1'b1;
                     rsp_found_in  = 1'b0;
                     rsp_value_in  = '0;
                     node_in       = AW'(root_ff);
                     missed_in     = 1'b0;
                  end
               end else begin
                  key_in   = req_data_byte;
                  ptr_in   = node_ff;
                  state_in = stl_pkg::ST_COUNT;
               end
            end
         end
         stl_pkg::ST_COUNT: begin
            count_in = mem_q_ff;
            ptr_in   = node_ff + AW'(1);
            state_in = stl_pkg::ST_HASVAL;
         end
         stl_pkg::ST_HASVAL: begin
            if (key_ff == stl_pkg::KEY_END) begin
               if (mem_q_ff == 8'h00) begin
                  rsp_strobe_in = 1'b1;
                  rsp_found_in  = 1'b0;
                  rsp_value_in  = '0;
                  node_in       = AW'(root_ff);
                  missed_in     = 1'b0;
                  state_in      = stl_pkg::ST_IDLE;
               end else begin
                  ptr_in   = node_ff + AW'(val_pos);
                  bcnt_in  = '0;
                  state_in = stl_pkg::ST_VALUE;
               end
            end else if (count_ff == 8'h00) begin
               missed_in = 1'b1;
               state_in  = stl_pkg::ST_IDLE;
            end else begin
               ptr_in   = node_ff + AW'(2);
               idx_in   = '0;
               state_in = stl_pkg::ST_SCAN;
            end
         end
         stl_pkg::ST_SCAN: begin
            if (mem_q_ff == key_ff) begin
               ptr_in   = node_ff + AW'(off_pos);
               bcnt_in  = '0;
               state_in = stl_pkg::ST_OFFSET;
            end else if (idx_ff == count_ff - 8'd1) begin
               missed_in = 1'b1;
               state_in  = stl_pkg::ST_IDLE;
            end else begin
               idx_in = idx_ff + 8'd1;
               ptr_in = ptr_ff + AW'(1);
            end
         end
         stl_pkg::ST_OFFSET: begin
            shift_in = shift_next;
            if (bcnt_ff == stl_pkg::OFF_LAST) begin
               node_in  = shift_next[32 +: AW];
               state_in = stl_pkg::ST_IDLE;
            end else begin
               bcnt_in = bcnt_ff + 3'd1;
               ptr_in  = ptr_ff + AW'(1);
            end
         end
         stl_pkg::ST_VALUE: begin
            shift_in = shift_next;
            if (bcnt_ff == stl_pkg::VAL_LAST) begin
               rsp_strobe_in = 1'b1;
               rsp_found_in  = 1'b1;
               rsp_value_in  = shift_next;
               node_in       = AW'(root_ff);
               missed_in     = 1'b0;
               state_in      = stl_pkg::ST_IDLE;
            end else begin
               bcnt_in = bcnt_ff + 3'd1;
               ptr_in  = ptr_ff + AW'(1);
            end
         end
         default: begin
            state_in = stl_pkg::ST_IDLE;
         end
      endcase

      if (cfg_we) begin
         root_in   = pwdata[stl_pkg::ROOT_W-1:0];
         node_in   = AW'(pwdata[stl_pkg::ROOT_W-1:0]);
         missed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= stl_pkg::ST_IDLE;
         node_ff       <= '0;
         missed_ff     <= 1'b0;
         root_ff       <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         node_ff       <= node_in;
         missed_ff     <= missed_in;
         root_ff       <= root_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff       <= ptr_in;
      count_ff     <= count_in;
      idx_ff       <= idx_in;
      bcnt_ff      <= bcnt_in;
      key_ff       <= key_in;
      shift_ff     <= shift_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
   end

   // A result only comes from the idle state, the has-value check or the value read.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == stl_pkg::ST_IDLE ||
                         $past(state_ff) == stl_pkg::ST_HASVAL ||
                         $past(state_ff) == stl_pkg::ST_VALUE))
      else $error("result transfer without a finished lookup");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_found_ff) |-> (rsp_value_ff == 64'd0))
      else $error("value is nonzero on a miss");

   // Every result restarts the walk at the root.
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> (node_ff == AW'(root_ff) && !missed_ff))
      else $error("walk not restarted after a result");

   assert property (@(posedge clock) disable iff (reset)
      busy |-> !missed_ff)
      else $error("sequencer running on a missed key");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == stl_pkg::ST_SCAN) |-> (idx_ff < count_ff))
      else $error("child scan ran past the child count");

endmodule

// ===== test/trie_walk_checker.sv =====
// Checker that follows the trie walk of the lookup block and compares every lookup result.
module trie_walk_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic                           busy,
   input  logic                           req_cmd,
   input  logic [11:0]                    req_addr,
   input  logic [7:0]                     req_data_byte,
   input  logic                           rsp_strobe,
   input  logic                           rsp_found,
   input  logic [63:0]                    rsp_value,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [stl_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [stl_pkg::CSR_DATA_W-1:0] pwdata,
   input  logic [stl_pkg::CSR_DATA_W-1:0] prdata,
   input  logic                           pready,
   output int                             failures,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [stl_pkg::CSR_ADDR_W-1:0] ROOT_ADDR = {stl_pkg::REG_ROOT_OFFSET, 2'b00};

   typedef struct packed {
      logic        found;
      logic [63:0] value;
   } answer_type;

   answer_type  answers_due[$];
   logic [7:0]  trie_bytes[stl_pkg::MEM_BYTES_DEFAULT];
   logic [11:0] root;
   logic [11:0] node;
   logic        missed;
   int          errors = 0;

   function automatic logic [7:0] byte_at(logic [11:0] base, int pos);
      logic [11:0] a;
      a = base + 12'(pos);
      return trie_bytes[a];
   endfunction

   function automatic logic [63:0] le_at(logic [11:0] base, int pos, int n);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < n; i++) v[8*i +: 8] = byte_at(base, pos + i);
      return v;
   endfunction

   task automatic walk_key_byte(logic [7:0] key);
      int          count;
      int          hit;
      logic [63:0] link;
      answer_type  a;
      count = int'(byte_at(node, 0));
      if (key == stl_pkg::KEY_END) begin
         a.found = !missed && byte_at(node, 1) != 8'd0;
         a.value = a.found ? le_at(node, 2 + 5 * count, 8) : 64'd0;
         answers_due.push_back(a);
         node = root;
         missed = 1'b0;
      end else if (!missed) begin
         hit = -1;
         for (int i = 0; i < count && hit < 0; i++)
            if (byte_at(node, 2 + i) == key) hit = i;
         if (hit < 0) begin
            missed = 1'b1;
         end else begin
            link = le_at(node, 2 + count + 4 * hit, 4);
            node = link[11:0];
         end
      end
   endtask

   always @(posedge clock) begin : monitor
      answer_type due;
      if (reset) begin
         root = '0;
         node = '0;
         missed = 1'b0;
         answers_due.delete();
      end else begin
         if (rsp_strobe === 1'b1) begin
            if (answers_due.size() == 0) begin
               errors++;
               $display("%0t: result with no lookup due: expected none, actual found %0b value %h",
                        $time, rsp_found, rsp_value);
            end else begin
               due = answers_due.pop_front();
               if (rsp_found !== due.found) begin
                  errors++;
                  $display("%0t: found mismatch: expected %0b, actual %0b",
                           $time, due.found, rsp_found);
               end
               if (rsp_value !== due.value) begin
                  errors++;
                  $display("%0t: value mismatch: expected %h, actual %h",
                           $time, due.value, rsp_value);
               end
            end
         end
         if (psel && penable && pready && paddr == ROOT_ADDR) begin
            if (pwrite) begin
               root = pwdata[11:0];
               node = root;
               missed = 1'b0;
            end else if (prdata !== stl_pkg::CSR_DATA_W'(root)) begin
               errors++;
               $display("%0t: root offset read mismatch: expected %h, actual %h",
                        $time, stl_pkg::CSR_DATA_W'(root), prdata);
            end
         end
         if (start && !busy) begin
            if (req_cmd == stl_pkg::CMD_WRITE) trie_bytes[req_addr] = req_data_byte;
            else walk_key_byte(req_data_byte);
         end
      end
      failures <= errors;
      pending <= answers_due.size();
   end

endmodule

// ===== test/serialized_trie_lookup_test.sv =====
// Testbench top for the trie lookup: clock, reset, trie loads, key transfers and the verdict.
module serialized_trie_lookup_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEMS = 950;
   localparam int MAX_NODES = 12;
   localparam int MAX_KIDS = 40;
   localparam int MAX_GAP = 12;
   localparam int SETTLE = 300;
   localparam logic [stl_pkg::CSR_ADDR_W-1:0] ROOT_ADDR = {stl_pkg::REG_ROOT_OFFSET, 2'b00};
   localparam logic [stl_pkg::CSR_ADDR_W-1:0] SPARE_ADDR = {1'b1, 2'b00};

   logic                           clock;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_cmd;
   logic [11:0]                    req_addr;
   logic [7:0]                     req_data_byte;
   logic                           rsp_strobe;
   logic                           rsp_found;
   logic [63:0]                    rsp_value;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [stl_pkg::CSR_ADDR_W-1:0] paddr;
   logic [stl_pkg::CSR_DATA_W-1:0] pwdata;
   logic [stl_pkg::CSR_DATA_W-1:0] prdata;
   logic                           pready;
   int                             failures;
   int                             pending;

   // Shape of the trie being loaded, kept to steer keys along real paths.
   int          node_count;
   logic [11:0] node_at[MAX_NODES];
   int          kid_count[MAX_NODES];
   logic [7:0]  kid_key[MAX_NODES][MAX_KIDS];
   int          kid_node[MAX_NODES][MAX_KIDS];
   logic [7:0]  value_flag[MAX_NODES];
   logic [63:0] node_value[MAX_NODES];
   logic [7:0]  image[4096];
   bit          in_trie[4096];
   int          walk_at;
   int          root_node;
   int          sent;
   bit          no_idle;

   serialized_trie_lookup dut (.*);

   trie_walk_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10ms;
      $display("status: fail");
      $finish;
   end

   function automatic int next_node(int at, logic [7:0] key);
      for (int i = 0; i < kid_count[at]; i++)
         if (kid_key[at][i] == key) return kid_node[at][i];
      return -1;
   endfunction

   function automatic void add_kid(int at, logic [7:0] key, int to);
      if (kid_count[at] < MAX_KIDS) begin
         kid_key[at][kid_count[at]] = key;
         kid_node[at][kid_count[at]] = to;
         kid_count[at]++;
      end
   endfunction

   function automatic void plan_trie(int nodes, int wide);
      int         p;
      logic [7:0] key;
      node_count = nodes;
      for (int i = 0; i < nodes; i++) begin
         kid_count[i] = 0;
         value_flag[i] = ($urandom_range(0, 2) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
         node_value[i] = {$urandom, $urandom};
      end
      for (int i = 1; i < nodes; i++) begin
         p = $urandom_range(0, i - 1);
         if (kid_count[p] > 0 && $urandom_range(0, 5) == 0)
            key = kid_key[p][$urandom_range(0, kid_count[p] - 1)];
         else
            key = 8'($urandom_range(1, 255));
         add_kid(p, key, i);
      end
      for (int i = 0; i < nodes; i++)
         if ($urandom_range(0, 3) == 0)
            add_kid(i, 8'($urandom_range(1, 255)), $urandom_range(0, nodes - 1));
      while (kid_count[0] < wide)
         add_kid(0, 8'($urandom_range(1, 255)), $urandom_range(0, nodes - 1));
   endfunction

   task automatic transfer(logic cmd, logic [11:0] addr, logic [7:0] data);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_cmd <= cmd;
      req_addr <= addr;
      req_data_byte <= data;
      do @(posedge clock); while (busy);
      sent++;
   endtask

   task automatic load_byte(inout logic [11:0] at, input logic [7:0] data);
      image[at] = data;
      in_trie[at] = 1'b1;
      transfer(stl_pkg::CMD_WRITE, at, data);
      at++;
   endtask

   task automatic load_trie(logic [11:0] base);
      logic [11:0] at;
      logic [31:0] link;
      for (int a = 0; a < 4096; a++) in_trie[a] = 1'b0;
      at = base;
      for (int i = 0; i < node_count; i++) begin
         node_at[i] = at;
         at += 12'(2 + 5 * kid_count[i] + (value_flag[i] != 8'd0 ? 8 : 0));
      end
      for (int i = 0; i < node_count; i++) begin
         at = node_at[i];
         load_byte(at, 8'(kid_count[i]));
         load_byte(at, value_flag[i]);
         for (int k = 0; k < kid_count[i]; k++) load_byte(at, kid_key[i][k]);
         for (int k = 0; k < kid_count[i]; k++) begin
            // Offsets carry random upper bits, which the memory size wraps away.
            link = {20'($urandom), node_at[kid_node[i][k]]};
            for (int b = 0; b < 4; b++) load_byte(at, link[8*b +: 8]);
         end
         if (value_flag[i] != 8'd0)
            for (int b = 0; b < 8; b++) load_byte(at, node_value[i][8*b +: 8]);
      end
   endtask

   task automatic key_byte(logic [7:0] key);
      transfer(stl_pkg::CMD_KEY, 12'($urandom), key);
      if (key == stl_pkg::KEY_END) walk_at = root_node;
      else if (walk_at >= 0) walk_at = next_node(walk_at, key);
   endtask

   task automatic stray_write();
      logic [11:0] a;
      a = 12'($urandom);
      transfer(stl_pkg::CMD_WRITE, a, in_trie[a] ? image[a] : 8'($urandom));
   endtask

   task automatic write_reg(logic [stl_pkg::CSR_ADDR_W-1:0] a, logic [31:0] data);
      start <= 1'b0;
      do @(posedge clock); while (pending != 0 || busy);
      repeat (SETTLE) @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= a;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic set_root(int n);
      write_reg(ROOT_ADDR, {20'($urandom), node_at[n]});
      root_node = n;
      walk_at = n;
   endtask

   initial begin : stimulus
      logic [11:0] base;
      bit          first;
      bit          well;
      int          len;
      start <= 1'b0;
      req_cmd <= stl_pkg::CMD_WRITE;
      req_addr <= '0;
      req_data_byte <= '0;
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= '0;
      pwdata <= '0;
      sent = 0;
      no_idle = 1'b0;
      reset <= 1'b1;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // A small fixed trie at address zero, walked from the root that reset leaves.
      node_count = 3;
      for (int i = 0; i < 3; i++) kid_count[i] = 0;
      add_kid(0, 8'hFF, 1);
      add_kid(0, 8'h01, 2);
      add_kid(0, 8'hFF, 0);
      add_kid(2, 8'h01, 0);
      value_flag[0] = 8'h00;
      value_flag[1] = 8'h80;
      value_flag[2] = 8'h01;
      node_value[1] = '1;
      node_value[2] = '0;
      load_trie(12'h000);
      root_node = 0;
      walk_at = 0;
      key_byte(stl_pkg::KEY_END);
      key_byte(8'hFF);
      key_byte(stl_pkg::KEY_END);
      key_byte(8'h01);
      key_byte(stl_pkg::KEY_END);
      key_byte(8'h01);
      key_byte(8'h01);
      stray_write();
      key_byte(8'hFF);
      key_byte(stl_pkg::KEY_END);
      key_byte(8'hFF);
      key_byte(8'hFF);
      key_byte(stl_pkg::KEY_END);
      key_byte(8'h33);
      key_byte(8'h01);
      key_byte(stl_pkg::KEY_END);
      key_byte(8'h01);
      set_root(0);
      key_byte(8'hFF);
      key_byte(stl_pkg::KEY_END);
      key_byte(8'h01);
      write_reg(SPARE_ADDR, $urandom);
      key_byte(8'h01);
      key_byte(8'hFF);
      key_byte(stl_pkg::KEY_END);

      // Random tries, the first rooted at the last address so that it wraps.
      first = 1'b1;
      while (sent < ITEMS) begin
         no_idle = ($urandom_range(0, 3) == 0);
         plan_trie($urandom_range(1, 10),
                   ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30) : 0);
         if (first) base = 12'hFFF;
         else if ($urandom_range(0, 3) == 0) base = 12'($urandom_range(4080, 4095));
         else base = 12'($urandom);
         first = 1'b0;
         load_trie(base);
         set_root(0);
         repeat ($urandom_range(4, 12)) begin
            well = ($urandom_range(0, 4) != 0);
            len = $urandom_range(0, 6);
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0) stray_write();
               if ($urandom_range(0, 29) == 0) set_root($urandom_range(0, node_count - 1));
               if (well && walk_at >= 0 && kid_count[walk_at] > 0 && $urandom_range(0, 7) != 0)
                  key_byte(kid_key[walk_at][$urandom_range(0, kid_count[walk_at] - 1)]);
               else
                  key_byte(8'($urandom_range(1, 255)));
            end
            key_byte(stl_pkg::KEY_END);
         end
      end

      start <= 1'b0;
      @(posedge clock);
      for (int c = 0; c < 20000 && pending != 0; c++) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (failures == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         if (pending != 0) $display("%0t: %0d lookup results never arrived", $time, pending);
         $display("status: fail");
      end
      $finish;
   end

endmodule
